>>> rtl/core/ple_pkg.sv
// Shared types and codes of the positional list engine.
package ple_pkg;

  localparam int SLOT_W = 6;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_READ_ALL  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CK_NONE = 2'd0,
    CK_INS  = 2'd1,
    CK_DEL  = 2'd2,
    CK_ROT  = 2'd3
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t         kind;
    logic [SLOT_W-1:0]  slot;
    logic signed [31:0] value;
  } cell_cmd_t;

endpackage

>>> rtl/core/ple_cell.sv
// One storage cell of the list chain, holding the entry at a fixed position.
module ple_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  ple_pkg::cell_cmd_t  cmd,
  input  logic signed [31:0]  prev_data,
  input  logic signed [31:0]  next_data,
  input  logic signed [31:0]  head_data,
  output logic signed [31:0]  data_out
);

  localparam logic [ple_pkg::SLOT_W-1:0] MY_IDX = ple_pkg::SLOT_W'(IDX);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd.kind)
      ple_pkg::CK_INS: begin
        if (MY_IDX > cmd.slot) begin
          data_nxt = prev_data;
        end else if (MY_IDX == cmd.slot) begin
          data_nxt = cmd.value;
        end
      end
      ple_pkg::CK_DEL: begin
        if (MY_IDX >= cmd.slot) begin
          data_nxt = next_data;
        end
      end
      ple_pkg::CK_ROT: begin
        if (MY_IDX == cmd.slot) begin
          data_nxt = head_data;
        end else if (MY_IDX < cmd.slot) begin
          data_nxt = next_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

>>> rtl/core/positional_list_engine_top.sv
// Top level of the positional list engine: request control and the cell chain.
//
// Requests arrive on the in_ stream, one word per request; results leave on
// the out_ stream, one word per result, with out_tlast on the final word of
// a request. Inserts and deletes answer with one status word; every cell of
// the chain loads its neighbor or the new value, or holds, in the cycle the
// request is accepted. A read-all answers with one word per element, front
// first, one per cycle while the receiver takes them; the chain rotates by
// one place per word and is back in its original order after the last one.
// A read-all on an empty list, like every status answer, is a single word.
// A request is taken only when the engine is idle and the output register
// is free or being emptied in that same cycle. A status word shows on out_
// in the cycle after its request is accepted; the first word of a read-all
// is registered from the read state that the request enters once accepted.
// When the receiver stalls, the output word holds and no further request or
// read-out step is taken. Reset empties the list and drops any pending output
// word; entry contents are not cleared and are never visible before being
// written.
module positional_list_engine_top #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pos[5:0], value[37:6], zero fill
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[1:0], value_res[33:2], index[39:34]
  output logic        out_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > ple_pkg::SLOT_W) ? CW : ple_pkg::SLOT_W;
  localparam int SW = ple_pkg::SLOT_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic [5:0]         out_index_r, out_index_nxt;
  logic               out_last_r, out_last_nxt;

  ple_pkg::cell_cmd_t cmd;
  logic signed [31:0] cell_q [CAPACITY];

  logic [5:0]         in_pos;
  logic signed [31:0] in_value;
  logic [2:0]         in_op;
  logic               out_free;
  logic               accept;
  logic               is_full;
  logic               is_empty;
  logic               bad_pos;
  logic               rd_last;

  assign in_pos   = in_tdata[5:0];
  assign in_value = in_tdata[37:6];
  assign in_op    = in_tuser;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign is_full   = (count_r >= CW'(CAPACITY));
  assign is_empty  = (count_r == '0);
  assign bad_pos   = (in_pos == 6'd0) || (PW'(in_pos) > PW'(count_r));
  assign rd_last   = ((CW'(rd_idx_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_last_nxt   = out_last_r;
    cmd.kind       = ple_pkg::CK_NONE;
    cmd.slot       = '0;
    cmd.value      = in_value;

    if (accept) begin
      out_value_nxt = '0;
      out_index_nxt = '0;
      out_last_nxt  = 1'b1;
      case (in_op)
        ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK: begin
          out_valid_nxt = 1'b1;
          if (is_full) begin
            out_status_nxt = ple_pkg::STAT_FULL;
          end else begin
            out_status_nxt = ple_pkg::STAT_OK;
            cmd.kind       = ple_pkg::CK_INS;
            cmd.slot       = (in_op == ple_pkg::OP_INS_FRONT) ? '0 : SW'(count_r);
            count_nxt      = count_r + CW'(1);
          end
        end
        ple_pkg::OP_INS_POS: begin
          out_valid_nxt = 1'b1;
          if (bad_pos) begin
            out_status_nxt = ple_pkg::STAT_BADPOS;
          end else if (is_full) begin
            out_status_nxt = ple_pkg::STAT_FULL;
          end else begin
            out_status_nxt = ple_pkg::STAT_OK;
            cmd.kind       = ple_pkg::CK_INS;
            cmd.slot       = in_pos - 6'd1;
            count_nxt      = count_r + CW'(1);
          end
        end
        ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: begin
          out_valid_nxt = 1'b1;
          if (is_empty) begin
            out_status_nxt = ple_pkg::STAT_EMPTY;
          end else begin
            out_status_nxt = ple_pkg::STAT_OK;
            cmd.kind       = ple_pkg::CK_DEL;
            cmd.slot       = (in_op == ple_pkg::OP_DEL_FRONT) ? '0 :
                             SW'(count_r - CW'(1));
            count_nxt      = count_r - CW'(1);
          end
        end
        ple_pkg::OP_DEL_POS: begin
          out_valid_nxt = 1'b1;
          if (bad_pos) begin
            out_status_nxt = ple_pkg::STAT_BADPOS;
          end else begin
            out_status_nxt = ple_pkg::STAT_OK;
            cmd.kind       = ple_pkg::CK_DEL;
            cmd.slot       = in_pos - 6'd1;
            count_nxt      = count_r - CW'(1);
          end
        end
        ple_pkg::OP_READ_ALL: begin
          if (is_empty) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ple_pkg::STAT_EMPTY;
          end else begin
            state_nxt  = S_READ;
            rd_idx_nxt = '0;
          end
        end
        default: begin
          out_last_nxt = out_last_r;
        end
      endcase
    end else if ((state_r == S_READ) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ple_pkg::STAT_OK;
      out_value_nxt  = cell_q[0];
      out_index_nxt  = 6'(rd_idx_r);
      out_last_nxt   = rd_last;
      cmd.kind       = ple_pkg::CK_ROT;
      cmd.slot       = SW'(count_r - CW'(1));
      rd_idx_nxt     = rd_idx_r + IW'(1);
      if (rd_last) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_last_r   <= out_last_nxt;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] prev_d;
      logic signed [31:0] next_d;
      if (g == 0) begin : g_first
        assign prev_d = '0;
      end else begin : g_mid_prev
        assign prev_d = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign next_d = '0;
      end else begin : g_mid_next
        assign next_d = cell_q[g+1];
      end
      ple_cell #(
        .IDX (g)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .prev_data (prev_d),
        .next_data (next_d),
        .head_data (cell_q[0]),
        .data_out  (cell_q[g])
      );
    end
  endgenerate

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_index_r, out_value_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

>>> sim/testbench.sv
// Self-checking stream testbench for the positional list engine, with a queue-based list model.
`timescale 1ns / 100ps

module testbench;

  localparam int CAP = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 120;
  localparam logic [2:0] OP_UNDEF = 3'd7;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic [5:0]  index;
    logic        last;
  } list_word_t;

  typedef struct {
    logic [2:0]       op;
    logic [5:0]       pos;
    logic [31:0]      value;
    bit               typed;
    ple_pkg::status_t st;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  logic [31:0] list_q [$];
  list_word_t  want_q [$];
  list_word_t  got_word;
  int          fail_cnt = 0;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  bit          growing = 1'b1;

  dir_row_t dir_rows [25] = '{
    '{ple_pkg::OP_READ_ALL,  6'd0,  32'h0000_0000, 1'b1, ple_pkg::STAT_EMPTY},
    '{ple_pkg::OP_DEL_FRONT, 6'd0,  32'h0000_0000, 1'b1, ple_pkg::STAT_EMPTY},
    '{ple_pkg::OP_DEL_BACK,  6'd0,  32'h0000_0000, 1'b1, ple_pkg::STAT_EMPTY},
    '{ple_pkg::OP_DEL_POS,   6'd1,  32'h0000_0000, 1'b1, ple_pkg::STAT_BADPOS},
    '{ple_pkg::OP_INS_POS,   6'd1,  32'h0000_0005, 1'b1, ple_pkg::STAT_BADPOS},
    '{ple_pkg::OP_INS_POS,   6'd0,  32'h0000_0005, 1'b1, ple_pkg::STAT_BADPOS},
    '{ple_pkg::OP_INS_FRONT, 6'd0,  32'h7fff_ffff, 1'b1, ple_pkg::STAT_OK},
    '{ple_pkg::OP_INS_BACK,  6'd0,  32'h8000_0000, 1'b1, ple_pkg::STAT_OK},
    '{ple_pkg::OP_INS_POS,   6'd1,  32'hffff_ffff, 1'b1, ple_pkg::STAT_OK},
    '{ple_pkg::OP_INS_POS,   6'd3,  32'h0000_0000, 1'b1, ple_pkg::STAT_OK},
    '{ple_pkg::OP_INS_POS,   6'd5,  32'h1111_1111, 1'b1, ple_pkg::STAT_BADPOS},
    '{ple_pkg::OP_INS_POS,   6'd63, 32'h5a5a_5a5a, 1'b1, ple_pkg::STAT_BADPOS},
    '{OP_UNDEF,              6'd63, 32'hffff_ffff, 1'b0, ple_pkg::STAT_OK},
    '{ple_pkg::OP_READ_ALL,  6'd0,  32'h0000_0000, 1'b0, ple_pkg::STAT_OK},
    '{ple_pkg::OP_DEL_POS,   6'd0,  32'h0000_0000, 1'b1, ple_pkg::STAT_BADPOS},
    '{ple_pkg::OP_DEL_POS,   6'd63, 32'h0000_0000, 1'b1, ple_pkg::STAT_BADPOS},
    '{ple_pkg::OP_DEL_POS,   6'd4,  32'h0000_0000, 1'b1, ple_pkg::STAT_OK},
    '{ple_pkg::OP_INS_POS,   6'd2,  32'h1234_5678, 1'b0, ple_pkg::STAT_OK},
    '{ple_pkg::OP_DEL_POS,   6'd1,  32'h0000_0000, 1'b1, ple_pkg::STAT_OK},
    '{ple_pkg::OP_READ_ALL,  6'd0,  32'h0000_0000, 1'b0, ple_pkg::STAT_OK},
    '{ple_pkg::OP_DEL_FRONT, 6'd0,  32'h0000_0000, 1'b1, ple_pkg::STAT_OK},
    '{ple_pkg::OP_DEL_BACK,  6'd0,  32'h0000_0000, 1'b1, ple_pkg::STAT_OK},
    '{ple_pkg::OP_DEL_POS,   6'd1,  32'h0000_0000, 1'b1, ple_pkg::STAT_OK},
    '{ple_pkg::OP_READ_ALL,  6'd0,  32'h0000_0000, 1'b1, ple_pkg::STAT_EMPTY},
    '{ple_pkg::OP_INS_BACK,  6'd0,  32'h0000_0001, 1'b0, ple_pkg::STAT_OK}
  };

  positional_list_engine_top #(
    .CAPACITY(CAP)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  function automatic list_word_t status_word(input ple_pkg::status_t st);
    list_word_t w;
    w.status = st;
    w.value  = 32'h0;
    w.index  = 6'd0;
    w.last   = 1'b1;
    return w;
  endfunction

  function automatic void list_apply(input logic [2:0] op, input logic [5:0] pos,
                                     input logic [31:0] value, output list_word_t res [$]);
    int n;
    list_word_t w;
    n = list_q.size();
    res.delete();
    case (op)
      ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK: begin
        if (n >= CAP) begin
          res.push_back(status_word(ple_pkg::STAT_FULL));
        end else begin
          if (op == ple_pkg::OP_INS_FRONT) list_q.push_front(value);
          else list_q.push_back(value);
          res.push_back(status_word(ple_pkg::STAT_OK));
        end
      end
      ple_pkg::OP_INS_POS: begin
        if (pos < 1 || pos > n) begin
          res.push_back(status_word(ple_pkg::STAT_BADPOS));
        end else if (n >= CAP) begin
          res.push_back(status_word(ple_pkg::STAT_FULL));
        end else begin
          list_q.insert(pos - 1, value);
          res.push_back(status_word(ple_pkg::STAT_OK));
        end
      end
      ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: begin
        if (n == 0) begin
          res.push_back(status_word(ple_pkg::STAT_EMPTY));
        end else begin
          if (op == ple_pkg::OP_DEL_FRONT) void'(list_q.pop_front());
          else void'(list_q.pop_back());
          res.push_back(status_word(ple_pkg::STAT_OK));
        end
      end
      ple_pkg::OP_DEL_POS: begin
        if (pos < 1 || pos > n) begin
          res.push_back(status_word(ple_pkg::STAT_BADPOS));
        end else begin
          list_q.delete(pos - 1);
          res.push_back(status_word(ple_pkg::STAT_OK));
        end
      end
      ple_pkg::OP_READ_ALL: begin
        if (n == 0) begin
          res.push_back(status_word(ple_pkg::STAT_EMPTY));
        end else begin
          for (int i = 0; i < n; i++) begin
            w.status = ple_pkg::STAT_OK;
            w.value  = list_q[i];
            w.index  = i[5:0];
            w.last   = (i == n - 1);
            res.push_back(w);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_word(input logic [2:0] op, input logic [5:0] pos, input logic [31:0] value,
                           input bit typed, input ple_pkg::status_t st);
    list_word_t res [$];
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {2'b00, value, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    list_apply(op, pos, value, res);
    if (typed) begin
      res.delete();
      res.push_back(status_word(st));
    end
    foreach (res[i]) want_q.push_back(res[i]);
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid = 1'b0;
    while (want_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic rand_items(input int n);
    int sent;
    int size;
    int r;
    logic [2:0] op;
    logic [5:0] pos;
    logic [31:0] value;
    sent = 0;
    while (sent < n) begin
      size = list_q.size();
      if (growing && size == CAP && $urandom_range(3) == 0) growing = 1'b0;
      else if (!growing && size == 0 && $urandom_range(2) == 0) growing = 1'b1;
      r = $urandom_range(99);
      value = $urandom;
      if ($urandom_range(9) == 0) value = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      pos = 6'($urandom_range(size + 1, 0));
      if (r < 8) begin
        op = ple_pkg::OP_READ_ALL;
      end else if (r < 13) begin
        op  = 3'($urandom_range(OP_UNDEF, ple_pkg::OP_INS_FRONT));
        pos = 6'($urandom_range(63, 0));
      end else if ((r < 82) == growing) begin
        op = 3'($urandom_range(ple_pkg::OP_INS_POS, ple_pkg::OP_INS_FRONT));
      end else begin
        op = 3'($urandom_range(ple_pkg::OP_DEL_POS, ple_pkg::OP_DEL_FRONT));
      end
      send_word(op, pos, value, 1'b0, ple_pkg::STAT_OK);
      if (op != OP_UNDEF) sent++;
    end
  endtask

  task automatic note_failure(input string what, input list_word_t w);
    if (fail_cnt < 10) begin
      $display("%s: expected st=%0d val=%h idx=%0d last=%0d, got st=%0d val=%h idx=%0d last=%0d",
               what, w.status, w.value, w.index, w.last,
               out_tdata[1:0], out_tdata[33:2], out_tdata[39:34], out_tlast);
    end
    fail_cnt++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      if (want_q.size() == 0) begin
        got_word = status_word(ple_pkg::STAT_OK);
        note_failure("unexpected word", got_word);
      end else begin
        got_word = want_q.pop_front();
        if (out_tdata[1:0] !== got_word.status || out_tdata[33:2] !== got_word.value ||
            out_tdata[39:34] !== got_word.index || out_tlast !== got_word.last) begin
          note_failure("mismatch", got_word);
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].value,
                dir_rows[i].typed, dir_rows[i].st);
    end
    drain();

    send_idle = 0;  recv_stall = 0;  rand_items(PHASE_ITEMS);  drain();
    send_idle = 73; recv_stall = 0;  rand_items(PHASE_ITEMS);  drain();
    send_idle = 0;  recv_stall = 73; rand_items(PHASE_ITEMS);  drain();
    send_idle = 8;  recv_stall = 8;  rand_items(PHASE_ITEMS);  drain();

    repeat (16) @(posedge clk);
    if (fail_cnt == 0 && want_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
